>>> src/kfc_pkg.sv
// ----------------------------------------------------------------------------
// kfc_pkg
// Shared types, key codes and helpers for the keypad four-function calculator.
// ----------------------------------------------------------------------------
package kfc_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 5;

  // keypad codes
  localparam logic [4:0] KEY_ADD   = 5'd4;
  localparam logic [4:0] KEY_SUB   = 5'd8;
  localparam logic [4:0] KEY_MUL   = 5'd12;
  localparam logic [4:0] KEY_DIV   = 5'd16;
  localparam logic [4:0] KEY_EQ    = 5'd13;
  localparam logic [4:0] KEY_CLEAR = 5'd15;

  localparam logic [6:0] CHAR_ZERO = 7'h30;
  localparam logic [6:0] CHAR_ADD  = 7'h2B;
  localparam logic [6:0] CHAR_SUB  = 7'h2D;
  localparam logic [6:0] CHAR_MUL  = 7'h2A;
  localparam logic [6:0] CHAR_DIV  = 7'h2F;
  localparam logic [6:0] CHAR_EQ   = 7'h3D;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
  } key_digit_t;

  // request into the shared multiply / divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] value;
  } alu_rsp_t;

  function automatic key_digit_t key_digit(logic [4:0] k);
    key_digit_t r;
    r.is_digit = 1'b1;
    r.digit    = 4'd0;
    unique case (k)
      5'd1:    r.digit = 4'd1;
      5'd2:    r.digit = 4'd2;
      5'd3:    r.digit = 4'd3;
      5'd5:    r.digit = 4'd4;
      5'd6:    r.digit = 4'd5;
      5'd7:    r.digit = 4'd6;
      5'd9:    r.digit = 4'd7;
      5'd10:   r.digit = 4'd8;
      5'd11:   r.digit = 4'd9;
      5'd14:   r.digit = 4'd0;
      default: r.is_digit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> src/kfc_alu.sv
// ----------------------------------------------------------------------------
// kfc_alu
// Shared 32-bit shift-add multiplier and restoring signed divider, one bit per
// cycle through a single 33-bit adder. done is a registered strobe after the last bit.
// ----------------------------------------------------------------------------
module kfc_alu
  import kfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  alu_req_t         req,
  input  logic [WordW-1:0] a,
  input  logic [WordW-1:0] b,
  output alu_rsp_t         rsp
);

  logic              busy;
  logic              fin;
  logic              is_div;
  logic              neg;
  logic [CountW-1:0] cnt;
  logic [WordW-1:0]  x;   // product accumulator / partial remainder
  logic [WordW-1:0]  y;   // shifted multiplicand / divisor magnitude
  logic [WordW-1:0]  z;   // multiplier / dividend shifting into quotient

  logic [WordW:0]    add_a;
  logic [WordW:0]    add_b;
  logic [WordW:0]    sum;
  logic [WordW-1:0]  mag_a;
  logic [WordW-1:0]  mag_b;

  assign mag_a = a[WordW-1] ? (WordW'(0) - a) : a;
  assign mag_b = b[WordW-1] ? (WordW'(0) - b) : b;

  // one adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    if (is_div) begin
      add_a = {x, z[WordW-1]};
      add_b = ~{1'b0, y};
    end else begin
      add_a = {1'b0, x};
      add_b = z[0] ? {1'b0, y} : '0;
    end
    sum = add_a + add_b + {{WordW{1'b0}}, is_div};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CountW'(1);
        if (cnt == CountW'(WordW - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div <= req.is_div;
      neg    <= a[WordW-1] ^ b[WordW-1];
      x      <= '0;
      y      <= req.is_div ? mag_b : a;
      z      <= req.is_div ? mag_a : b;
    end else if (busy) begin
      if (is_div) begin
        if (!sum[WordW]) begin
          x <= sum[WordW-1:0];
          z <= {z[WordW-2:0], 1'b1};
        end else begin
          x <= {x[WordW-2:0], z[WordW-1]};
          z <= {z[WordW-2:0], 1'b0};
        end
      end else begin
        x <= sum[WordW-1:0];
        y <= {y[WordW-2:0], 1'b0};
        z <= {1'b0, z[WordW-1:1]};
      end
    end
  end

  always_comb begin
    rsp.done = fin;
    if (is_div) begin
      rsp.value = neg ? (WordW'(0) - z) : z;
    end else begin
      rsp.value = x;
    end
  end

endmodule

>>> src/keypad_four_function_calculator.sv
// ----------------------------------------------------------------------------
// keypad_four_function_calculator
// Keypad calculator: digit entry, four operators, equals and clear.
// ----------------------------------------------------------------------------
// channel  dir  width  contents
// s_axis   in   8      [4:0] key_code
// m_axis   out  48     [6:0] echo_char, [7] clear_screen, [8] result_valid,
//                      [40:9] result_value, [41] divide_error, [42] digit_dropped
//
// Keys that need no multiply or divide: result registered at the edge after
// accept. Equals with multiply or a nonzero divide runs the shared bit-serial
// unit before the result is offered. One item at a time; tready is low until
// the result has been taken. Synchronous active-high reset.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator
  import kfc_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 31
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] key_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // echo_char, clear_screen, result_valid,
                                      // result_value, divide_error, digit_dropped
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t            state;
  logic [WordW-1:0]  entry_value;
  logic [CountW-1:0] digit_count;
  logic [WordW-1:0]  first_operand;
  logic [WordW-1:0]  second_operand;
  op_t               pending_operation;

  logic [6:0]        echo_char;
  logic              clear_screen;
  logic              result_valid;
  logic [WordW-1:0]  result_value;
  logic              divide_error;
  logic              digit_dropped;

  logic              accept;
  logic [4:0]        key_code;
  key_digit_t        kd;
  logic              has_digits;
  logic [WordW-1:0]  opnd_b;
  logic [WordW-1:0]  entry_times10;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign key_code      = s_axis_tdata[4:0];
  assign kd            = key_digit(key_code);
  assign has_digits    = (digit_count != '0);
  // equals takes the new entry when digits are pending, else the old operand
  assign opnd_b        = has_digits ? entry_value : second_operand;
  assign entry_times10 = {entry_value[WordW-4:0], 3'b000} + {entry_value[WordW-2:0], 1'b0};

  always_comb begin
    alu_req.start  = 1'b0;
    alu_req.is_div = (pending_operation == OP_DIV);
    if (accept && key_code == KEY_EQ) begin
      if (pending_operation == OP_MUL) begin
        alu_req.start = 1'b1;
      end else if (pending_operation == OP_DIV && opnd_b != '0) begin
        alu_req.start = 1'b1;
      end
    end
  end

  kfc_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (first_operand),
    .b   (opnd_b),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      entry_value       <= '0;
      digit_count       <= '0;
      first_operand     <= '0;
      second_operand    <= '0;
      pending_operation <= OP_NONE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= alu_req.start ? ST_CALC : ST_OUT;
            if (kd.is_digit) begin
              if (digit_count < CountW'(MAX_DIGITS)) begin
                entry_value <= entry_times10 + {{(WordW-4){1'b0}}, kd.digit};
                digit_count <= digit_count + CountW'(1);
              end
            end else if (key_code == KEY_ADD || key_code == KEY_SUB ||
                         key_code == KEY_MUL || key_code == KEY_DIV) begin
              if (has_digits) begin
                first_operand <= entry_value;
                entry_value   <= '0;
                digit_count   <= '0;
                priority case (key_code)
                  KEY_ADD: pending_operation <= OP_ADD;
                  KEY_SUB: pending_operation <= OP_SUB;
                  KEY_MUL: pending_operation <= OP_MUL;
                  default: pending_operation <= OP_DIV;
                endcase
              end
            end else if (key_code == KEY_EQ) begin
              if (has_digits) begin
                second_operand <= entry_value;
              end
            end else if (key_code == KEY_CLEAR) begin
              entry_value       <= '0;
              digit_count       <= '0;
              first_operand     <= '0;
              second_operand    <= '0;
              pending_operation <= OP_NONE;
            end
          end
        end
        ST_CALC: begin
          if (alu_rsp.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      echo_char     <= '0;
      clear_screen  <= 1'b0;
      result_valid  <= 1'b0;
      result_value  <= '0;
      divide_error  <= 1'b0;
      digit_dropped <= 1'b0;
      if (kd.is_digit) begin
        if (digit_count < CountW'(MAX_DIGITS)) begin
          echo_char <= CHAR_ZERO + {3'b000, kd.digit};
        end else begin
          digit_dropped <= 1'b1;
        end
      end else if (key_code == KEY_ADD || key_code == KEY_SUB ||
                   key_code == KEY_MUL || key_code == KEY_DIV) begin
        if (has_digits) begin
          priority case (key_code)
            KEY_ADD: echo_char <= CHAR_ADD;
            KEY_SUB: echo_char <= CHAR_SUB;
            KEY_MUL: echo_char <= CHAR_MUL;
            default: echo_char <= CHAR_DIV;
          endcase
        end
      end else if (key_code == KEY_EQ) begin
        if (has_digits) begin
          echo_char <= CHAR_EQ;
        end
        unique case (pending_operation)
          OP_ADD: begin
            result_valid <= 1'b1;
            result_value <= first_operand + opnd_b;
          end
          OP_SUB: begin
            result_valid <= 1'b1;
            result_value <= first_operand - opnd_b;
          end
          OP_DIV: begin
            if (opnd_b == '0) begin
              divide_error <= 1'b1;
            end
          end
          default: ;
        endcase
      end else if (key_code == KEY_CLEAR) begin
        clear_screen <= 1'b1;
      end
    end else if (state == ST_CALC && alu_rsp.done) begin
      result_valid <= 1'b1;
      result_value <= alu_rsp.value;
    end
  end

  assign m_axis_tdata = {5'b00000, digit_dropped, divide_error, result_value,
                         result_valid, clear_screen, echo_char};

endmodule

>>> tb/keypad_four_function_calculator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_four_function_calculator_tb
// Self-checking bench for the keypad calculator. A short table of directed
// keys comes first, then random key sequences with random gaps on both
// streams. Every result item is checked against a behavioral calculator
// kept in the bench, or against the typed result of a directed row.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator_tb;
  import kfc_pkg::*;

  localparam int unsigned MAX_DIGITS   = 31;
  localparam int          ITEM_TARGET  = 1350;
  localparam int          HOLD_AT      = 250;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 60;

  // key codes that the calculator ignores
  localparam logic [4:0] KEY_IDLE_LO = 5'd0;
  localparam logic [4:0] KEY_IDLE_HI = 5'd31;

  // digit keys, digit 0 in the lowest slot
  localparam logic [49:0] DIGIT_KEYS = {5'd11, 5'd10, 5'd9, 5'd7, 5'd6,
                                        5'd5, 5'd3, 5'd2, 5'd1, 5'd14};

  typedef struct packed {
    logic [6:0]  echo;
    logic        clr;
    logic        valid;
    logic [31:0] value;
    logic        derr;
    logic        drop;
  } calc_out_t;

  typedef struct packed {
    logic [4:0] key;
    logic       typed;
    calc_out_t  want;
  } key_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [4:0] key_code
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // echo_char, clear_screen, result_valid,
                               // result_value, divide_error, digit_dropped

  // calculator state as the bench sees it
  logic [31:0] key_entry;
  logic [4:0]  key_digits;
  logic [31:0] lhs;
  logic [31:0] rhs;
  op_t         op_held;

  calc_out_t results_due[$];
  key_row_t  key_table[$];

  int n_sent;
  int n_checked;
  int n_err;
  int n_valid;
  int n_div0;
  int n_drop;
  int n_clr;

  keypad_four_function_calculator #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** keypad_four_function_calculator: FAILED **");
    $finish;
  end

  function automatic logic [4:0] dkey(int d);
    return DIGIT_KEYS[d*5 +: 5];
  endfunction

  function automatic int digit_value(logic [4:0] k);
    for (int d = 0; d < 10; d++) begin
      if (DIGIT_KEYS[d*5 +: 5] == k) return d;
    end
    return -1;
  endfunction

  function automatic logic [4:0] pick_op();
    case ($urandom_range(0, 3))
      0: return KEY_ADD;
      1: return KEY_SUB;
      2: return KEY_MUL;
      default: return KEY_DIV;
    endcase
  endfunction

  function automatic calc_out_t typed_out(logic [6:0] echo, logic clr, logic derr);
    calc_out_t r;
    r      = '0;
    r.echo = echo;
    r.clr  = clr;
    r.derr = derr;
    return r;
  endfunction

  function automatic void add_row(logic [4:0] k, logic typed, calc_out_t want);
    key_row_t row;
    row.key   = k;
    row.typed = typed;
    row.want  = want;
    key_table.push_back(row);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_calc();
    key_entry  = '0;
    key_digits = '0;
    lhs        = '0;
    rhs        = '0;
    op_held    = OP_NONE;
  endfunction

  // applies one key to the bench copy of the calculator, returns its result
  function automatic calc_out_t calc_key(logic [4:0] k);
    calc_out_t   r;
    int          d;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    r = '0;
    d = digit_value(k);
    if (d >= 0) begin
      if (key_digits < MAX_DIGITS) begin
        r.echo     = CHAR_ZERO + 7'(d);
        key_entry  = key_entry * 32'd10 + 32'(d);
        key_digits = key_digits + 5'd1;
      end else begin
        r.drop = 1'b1;
        n_drop++;
      end
    end else begin
      case (k)
        KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
          if (key_digits != 0) begin
            case (k)
              KEY_ADD: begin op_held = OP_ADD; r.echo = CHAR_ADD; end
              KEY_SUB: begin op_held = OP_SUB; r.echo = CHAR_SUB; end
              KEY_MUL: begin op_held = OP_MUL; r.echo = CHAR_MUL; end
              default: begin op_held = OP_DIV; r.echo = CHAR_DIV; end
            endcase
            lhs        = key_entry;
            key_entry  = '0;
            key_digits = '0;
          end
        end
        KEY_EQ: begin
          // the entry stays open after equals
          if (key_digits != 0) begin
            r.echo = CHAR_EQ;
            rhs    = key_entry;
          end
          case (op_held)
            OP_ADD: begin r.valid = 1'b1; r.value = lhs + rhs; end
            OP_SUB: begin r.valid = 1'b1; r.value = lhs - rhs; end
            OP_MUL: begin r.valid = 1'b1; r.value = lhs * rhs; end
            OP_DIV: begin
              if (rhs == 0) begin
                r.derr = 1'b1;
                n_div0++;
              end else begin
                // magnitudes, then sign; min / -1 wraps back to min
                ma      = lhs[31] ? -lhs : lhs;
                mb      = rhs[31] ? -rhs : rhs;
                q       = ma / mb;
                r.valid = 1'b1;
                r.value = (lhs[31] != rhs[31]) ? -q : q;
              end
            end
            default: ;
          endcase
          if (r.valid) n_valid++;
        end
        KEY_CLEAR: begin
          r.clr = 1'b1;
          clear_calc();
          n_clr++;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic send_key(input logic [4:0] k, input logic typed = 1'b0,
                          input calc_out_t want = '0);
    int        gap;
    calc_out_t pred;
    gap = ((n_sent / 200) % 4 == 2) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, k};
    do @(posedge clk); while (!s_axis_tready);
    pred = calc_key(k);
    results_due.push_back(typed ? want : pred);
    n_sent++;
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_key(dkey($urandom_range(0, 9)));
  endtask

  task automatic send_decimal(input string s);
    for (int i = 0; i < s.len(); i++) send_key(dkey(int'(s[i] - "0")));
  endtask

  task automatic send_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_digits($urandom_range(1, 4));
    end else if (r < 75) begin
      send_digits($urandom_range(5, 10));
    end else if (r < 85) begin
      case ($urandom_range(0, 5))
        0: send_decimal("0");
        1: send_decimal("1");
        2: send_decimal("2147483647");
        3: send_decimal("2147483648");
        4: send_decimal("4294967295");
        default: send_decimal("10");
      endcase
    end else if (r < 91) begin
      // fills the entry, the rest is dropped
      send_digits($urandom_range(31, 34));
    end
    // otherwise no digits at all
  endtask

  task automatic flag(input string what, input logic [31:0] e, input logic [31:0] g);
    n_err++;
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, e, g);
  endtask

  // result side: random stalls, one long hold-off while keys keep coming
  initial begin : result_side
    int        stall;
    logic      held;
    calc_out_t got;
    calc_out_t want;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!held && n_checked >= HOLD_AT) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else begin
        stall = ((n_checked / 200) % 4 == 3) ? 0 : idle_len();
      end
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      got.echo  = m_axis_tdata[6:0];
      got.clr   = m_axis_tdata[7];
      got.valid = m_axis_tdata[8];
      got.value = m_axis_tdata[40:9];
      got.derr  = m_axis_tdata[41];
      got.drop  = m_axis_tdata[42];
      if (results_due.size() == 0) begin
        flag("unexpected item", '0, got.value);
      end else begin
        want = results_due.pop_front();
        if (got.echo  !== want.echo)  flag("echo_char", want.echo, got.echo);
        if (got.clr   !== want.clr)   flag("clear_screen", want.clr, got.clr);
        if (got.valid !== want.valid) flag("result_valid", want.valid, got.valid);
        if (got.value !== want.value) flag("result_value", want.value, got.value);
        if (got.derr  !== want.derr)  flag("divide_error", want.derr, got.derr);
        if (got.drop  !== want.drop)  flag("digit_dropped", want.drop, got.drop);
      end
      n_checked++;
    end
  end

  initial begin : key_side
    int r;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    n_sent        = 0;
    n_checked     = 0;
    n_err         = 0;
    n_valid       = 0;
    n_div0        = 0;
    n_drop        = 0;
    n_clr         = 0;
    clear_calc();

    // directed keys; typed rows hold the result that is obvious by hand
    add_row(KEY_EQ,      1'b1, typed_out('0, 1'b0, 1'b0));  // equals, nothing held
    add_row(KEY_IDLE_LO, 1'b1, typed_out('0, 1'b0, 1'b0));
    add_row(KEY_IDLE_HI, 1'b1, typed_out('0, 1'b0, 1'b0));
    add_row(KEY_ADD,     1'b1, typed_out('0, 1'b0, 1'b0));  // operator, no digits
    add_row(dkey(7),     1'b1, typed_out(CHAR_ZERO + 7'd7, 1'b0, 1'b0));
    add_row(KEY_DIV,     1'b1, typed_out(CHAR_DIV, 1'b0, 1'b0));
    add_row(dkey(0),     1'b1, typed_out(CHAR_ZERO, 1'b0, 1'b0));
    add_row(KEY_EQ,      1'b1, typed_out(CHAR_EQ, 1'b0, 1'b1));  // divide by zero
    add_row(KEY_EQ,      1'b1, typed_out(CHAR_EQ, 1'b0, 1'b1));  // open zero entry again
    add_row(dkey(5),     1'b0, '0);  // entry carries on after equals
    add_row(KEY_EQ,      1'b0, '0);
    add_row(KEY_CLEAR,   1'b1, typed_out('0, 1'b1, 1'b0));
    add_row(dkey(3),     1'b0, '0);
    add_row(KEY_SUB,     1'b0, '0);
    add_row(dkey(8),     1'b0, '0);
    add_row(KEY_EQ,      1'b0, '0);
    add_row(dkey(6),     1'b0, '0);
    add_row(KEY_MUL,     1'b0, '0);
    add_row(dkey(1),     1'b0, '0);
    add_row(KEY_EQ,      1'b0, '0);
    add_row(dkey(4),     1'b0, '0);
    add_row(KEY_ADD,     1'b0, '0);
    add_row(dkey(9),     1'b0, '0);
    add_row(KEY_EQ,      1'b0, '0);
    add_row(KEY_CLEAR,   1'b1, typed_out('0, 1'b1, 1'b0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (key_table[i]) send_key(key_table[i].key, key_table[i].typed, key_table[i].want);

    while (n_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 18) begin
        repeat ($urandom_range(1, 6)) send_key(5'($urandom_range(0, 31)));
      end else if (r < 22) begin
        // most negative value against minus one
        send_decimal("2147483648");
        send_key(pick_op());
        send_decimal("4294967295");
        send_key(KEY_EQ);
      end else begin
        send_number();
        send_key(pick_op());
        send_number();
        send_key(KEY_EQ);
        r = $urandom_range(0, 99);
        if (r < 20) begin
          repeat ($urandom_range(1, 3)) send_key(KEY_EQ);
        end else if (r < 35) begin
          send_number();
          send_key(KEY_EQ);
        end else if (r < 45) begin
          send_key(pick_op());
        end
        if ($urandom_range(0, 99) < 15) send_key(KEY_CLEAR);
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("keys sent %0d, results checked %0d, mismatches %0d",
             n_sent, n_checked, n_err);
    $display("computed results %0d, divide-by-zero %0d, dropped digits %0d, clears %0d",
             n_valid, n_div0, n_drop, n_clr);
    if (n_err == 0) begin
      $display("** keypad_four_function_calculator: PASSED **");
    end else begin
      $display("** keypad_four_function_calculator: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
src/kfc_pkg.sv
src/kfc_alu.sv
src/keypad_four_function_calculator.sv
tb/keypad_four_function_calculator_tb.sv
